FILE: rtl/keypad_code_lock_unit_assert.svh
// Assertion macros used by the keypad code lock core (kcl_core).
`ifndef KEYPAD_CODE_LOCK_UNIT_ASSERT_SVH
`define KEYPAD_CODE_LOCK_UNIT_ASSERT_SVH

// Clocked check, off while reset is asserted; uses clk_i / rst_ni of the module.
`define KCL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("keypad code lock assertion failed");

// Same check with a caller-supplied message string.
`define KCL_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

`endif

FILE: rtl/kcl_pkg.sv
// Types, constants and helper functions of the keypad code lock.
`timescale 1ns / 1ps
package kcl_pkg;

  localparam int CODE_DIGITS = 4;
  localparam int IDX_W       = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
  localparam int CNT_W       = $clog2(CODE_DIGITS + 1);
  localparam int DIGIT_W     = 4;
  localparam int CODE_W      = 16;
  localparam int KEY_W       = 8;
  localparam int POT_W       = 10;
  localparam int SEG_W       = 7;
  localparam int DCNT_W      = 3;
  localparam int BLINK_W     = 10;
  localparam int ELAPSED_W   = 16;
  localparam int LIMIT_W     = 15;

  localparam logic [CODE_W-1:0]    MASTER_RESET = 16'h0316;
  localparam logic [BLINK_W-1:0]   BLINK_TOTAL  = 10'd600;
  localparam logic [BLINK_W-1:0]   BLINK_PHASE  = 10'd100;
  localparam logic [LIMIT_W-1:0]   DELAY_MIN    = 15'd5000;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX  = 16'hFFFF;

  localparam logic [KEY_W-1:0] KEY_ZERO = 8'h30;
  localparam logic [KEY_W-1:0] KEY_NINE = 8'h39;
  localparam logic [KEY_W-1:0] KEY_STAR = 8'h2A;

  // pot * 25000 / 1023 as one multiply by a rounded-up reciprocal.
  // Error stays below 1/1023 over the whole pot range, so truncation is exact.
  localparam int          RECIP_SHIFT = 21;
  localparam int          RECIP_W     = 26;
  localparam logic [63:0] RECIP_FULL  = ((64'd25000 << RECIP_SHIFT) + 64'd1022) / 64'd1023;
  localparam logic [RECIP_W-1:0] RECIP_MULT = RECIP_FULL[RECIP_W-1:0];
  localparam int          PROD_W      = POT_W + RECIP_W;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_TAKEN    = 3'd1,
    EV_ERASED   = 3'd2,
    EV_NO_ERASE = 3'd3,
    EV_GRANTED  = 3'd4,
    EV_WRONG    = 3'd5,
    EV_RELOCKED = 3'd6
  } kcl_event_e;

  typedef struct packed {
    logic                  op;
    logic [KEY_W-1:0]      key_code;
    logic [LIMIT_W-1:0]    relock_limit;
  } kcl_item_t;

  typedef struct packed {
    logic      valid;
    kcl_item_t item;
  } kcl_stage_t;

  typedef struct packed {
    logic              is_locked;
    logic              red_led;
    logic              green_led;
    logic [SEG_W-1:0]  segments;
    logic [DCNT_W-1:0] digit_count;
    kcl_event_e        event_res;
  } kcl_result_t;

  function automatic logic [SEG_W-1:0] seg_decode(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] s;
    unique case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = '0;
    endcase
    return s;
  endfunction

  // Digit expected at entry position pos; positions past the code word read as 0.
  function automatic logic [DIGIT_W-1:0] expected_digit(input logic [CODE_W-1:0] code,
                                                        input int pos);
    int sh;
    sh = (CODE_DIGITS - 1 - pos) * DIGIT_W;
    if (sh >= CODE_W) return '0;
    return DIGIT_W'(code >> sh);
  endfunction

endpackage

FILE: rtl/kcl_req_if.sv
// Request channel of the keypad code lock: key event or millisecond tick.
`timescale 1ns / 1ps
interface kcl_req_if;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [kcl_pkg::KEY_W-1:0] key_code;
  logic [kcl_pkg::POT_W-1:0] pot_sample;

  modport source (output valid, output op, output key_code, output pot_sample,
                  input ready);
  modport sink   (input valid, input op, input key_code, input pot_sample,
                  output ready);
endinterface

FILE: rtl/kcl_res_if.sv
// Result channel of the keypad code lock: lamp, display and event status.
`timescale 1ns / 1ps
interface kcl_res_if;
  logic                       valid;
  logic                       ready;
  logic                       is_locked;
  logic                       red_led;
  logic                       green_led;
  logic [kcl_pkg::SEG_W-1:0]  segments;
  logic [kcl_pkg::DCNT_W-1:0] digit_count;
  logic [2:0]                 event_res;

  modport source (output valid, output is_locked, output red_led, output green_led,
                  output segments, output digit_count, output event_res,
                  input ready);
  modport sink   (input valid, input is_locked, input red_led, input green_led,
                  input segments, input digit_count, input event_res,
                  output ready);
endinterface

FILE: rtl/kcl_in_stage.sv
// Input register of the lock; works out the relock limit from the pot sample.
`timescale 1ns / 1ps
module kcl_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  kcl_req_if.sink             req_i,
  input  logic                advance_i,
  output kcl_pkg::kcl_stage_t stage_o
);
  import kcl_pkg::*;

  logic                valid_q;
  kcl_item_t           item_q, item_d;
  logic                accept;
  logic [PROD_W-1:0]   prod;
  logic [LIMIT_W-1:0]  quot;

  assign req_i.ready = !valid_q || advance_i;
  assign accept      = req_i.valid && req_i.ready;

  assign prod = PROD_W'(req_i.pot_sample) * PROD_W'(RECIP_MULT);
  assign quot = prod[RECIP_SHIFT +: LIMIT_W];

  always_comb begin
    item_d.op           = req_i.op;
    item_d.key_code     = req_i.key_code;
    item_d.relock_limit = DELAY_MIN + quot;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.item  = item_q;

endmodule

FILE: rtl/kcl_core.sv
// Lock state and the per-request update: entry, compare, blink and relock timer.
`timescale 1ns / 1ps
`include "keypad_code_lock_unit_assert.svh"
module kcl_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [kcl_pkg::CODE_W-1:0]  cfg_data_i,
  input  kcl_pkg::kcl_stage_t         stage_i,
  input  logic                        advance_i,
  output logic                        fire_o,
  output kcl_pkg::kcl_result_t        result_o
);
  import kcl_pkg::*;

  logic [CODE_W-1:0]    master_q;
  logic                 locked_q, locked_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [ELAPSED_W-1:0] elapsed_q, elapsed_d, elapsed_inc;
  logic [BLINK_W-1:0]   blink_q, blink_d;
  logic [SEG_W-1:0]     seg_q, seg_d;
  logic [CODE_DIGITS-1:0][DIGIT_W-1:0] digits_q, digits_d;
  kcl_event_e           ev;
  logic                 is_digit;
  logic                 match;
  logic                 red;
  logic [DIGIT_W-1:0]   digit;

  assign fire_o   = stage_i.valid && advance_i;
  assign is_digit = (stage_i.item.key_code >= KEY_ZERO) && (stage_i.item.key_code <= KEY_NINE);
  assign digit    = stage_i.item.key_code[DIGIT_W-1:0];
  assign elapsed_inc = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + 1'b1;

  always_comb begin
    match = 1'b1;
    for (int i = 0; i < CODE_DIGITS; i++) begin
      if (digits_d[i] != expected_digit(master_q, i)) match = 1'b0;
    end
  end

  always_comb begin
    locked_d  = locked_q;
    cnt_d     = cnt_q;
    elapsed_d = elapsed_q;
    blink_d   = blink_q;
    seg_d     = seg_q;
    digits_d  = digits_q;
    ev        = EV_NONE;
    if (locked_q) begin
      if (stage_i.item.op) begin
        if (blink_q != '0) blink_d = blink_q - 1'b1;
      end else if (blink_q == '0) begin
        if (is_digit) begin
          if (cnt_q < CNT_W'(CODE_DIGITS)) begin
            digits_d[cnt_q[IDX_W-1:0]] = digit;
            cnt_d = cnt_q + 1'b1;
            seg_d = seg_decode(digit);
            ev    = EV_TAKEN;
          end
          // last digit in: check the code at once
          if (cnt_d == CNT_W'(CODE_DIGITS)) begin
            seg_d = '0;
            if (match) begin
              locked_d  = 1'b0;
              elapsed_d = '0;
              ev        = EV_GRANTED;
            end else begin
              cnt_d   = '0;
              blink_d = BLINK_TOTAL;
              ev      = EV_WRONG;
            end
          end
        end else if (stage_i.item.key_code == KEY_STAR) begin
          if (cnt_q != '0) begin
            cnt_d = cnt_q - 1'b1;
            seg_d = '0;
            ev    = EV_ERASED;
          end else begin
            ev = EV_NO_ERASE;
          end
        end
      end
    end else if (stage_i.item.op) begin
      elapsed_d = elapsed_inc;
      if (elapsed_inc > ELAPSED_W'(stage_i.item.relock_limit)) begin
        locked_d = 1'b1;
        cnt_d    = '0;
        seg_d    = '0;
        ev       = EV_RELOCKED;
      end
    end
  end

  // Blink counts down from BLINK_TOTAL: off, on, off, on, off, on in equal phases.
  always_comb begin
    if (!locked_d) begin
      red = 1'b0;
    end else if (blink_d == '0) begin
      red = 1'b1;
    end else begin
      red = (blink_d <= BLINK_PHASE) ||
            ((blink_d > BLINK_W'(2 * BLINK_PHASE)) && (blink_d <= BLINK_W'(3 * BLINK_PHASE))) ||
            ((blink_d > BLINK_W'(4 * BLINK_PHASE)) && (blink_d <= BLINK_W'(5 * BLINK_PHASE)));
    end
  end

  always_comb begin
    result_o.is_locked   = locked_d;
    result_o.red_led     = red;
    result_o.green_led   = !locked_d;
    result_o.segments    = seg_d;
    result_o.digit_count = DCNT_W'(cnt_d);
    result_o.event_res   = ev;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      master_q <= MASTER_RESET;
    end else if (cfg_we_i) begin
      master_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      locked_q  <= 1'b1;
      cnt_q     <= '0;
      elapsed_q <= '0;
      blink_q   <= '0;
      seg_q     <= '0;
    end else if (fire_o) begin
      locked_q  <= locked_d;
      cnt_q     <= cnt_d;
      elapsed_q <= elapsed_d;
      blink_q   <= blink_d;
      seg_q     <= seg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_o) begin
      digits_q <= digits_d;
    end
  end

  `KCL_ASSERT(a_unlocked_full, !locked_q |-> (cnt_q == CNT_W'(CODE_DIGITS)))
  `KCL_ASSERT(a_blink_locked, (blink_q != '0) |-> (locked_q && cnt_q == '0))
  `KCL_ASSERT_MSG(a_blink_range, blink_q <= BLINK_TOTAL, "blink counter out of range")
  `KCL_ASSERT(a_grant_unlocks, (fire_o && ev == EV_GRANTED) |=> !locked_q)

endmodule

FILE: rtl/kcl_out_stage.sv
// Result register of the lock, held until the receiver takes it.
`timescale 1ns / 1ps
module kcl_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  kcl_pkg::kcl_result_t result_i,
  output logic                 advance_o,
  kcl_res_if.source            res_o
);
  import kcl_pkg::*;

  logic        valid_q;
  kcl_result_t result_q;

  assign advance_o = !valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (res_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign res_o.valid       = valid_q;
  assign res_o.is_locked   = result_q.is_locked;
  assign res_o.red_led     = result_q.red_led;
  assign res_o.green_led   = result_q.green_led;
  assign res_o.segments    = result_q.segments;
  assign res_o.digit_count = result_q.digit_count;
  assign res_o.event_res   = result_q.event_res;

endmodule

FILE: rtl/keypad_code_lock_unit.sv
// Keypad code lock: a request is a key press or a millisecond tick with a pot
// sample; each request returns one result with lock state, lamps, display
// pattern, digit count and an event code.
// Channels: req_i (sink) and res_o (source), valid/ready, a request moves on
// the edge where both are high. cfg_we_i/cfg_data_i write the four-digit
// master code (BCD, first digit on top); write only while no request is open.
// Path: a request taken by the input register passes the update logic into the
// result register, from which res_o hands it over (input register, then
// result register). Throughput: one request per cycle while res_o is not
// held; the step is a single pass through the update logic and the
// pot-to-limit multiply sits in front of the input register.
// Reset: locked, no digits, display blank, timers zero, master code 0316.
// Stall: while res_o is held, the result register keeps its value and the
// input register still takes one more request; req_i.ready drops only when
// both are full.
`timescale 1ns / 1ps
module keypad_code_lock_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [kcl_pkg::CODE_W-1:0] cfg_data_i,
  kcl_req_if.sink                    req_i,
  kcl_res_if.source                  res_o
);
  import kcl_pkg::*;

  kcl_stage_t  stage;
  kcl_result_t result;
  logic        advance;
  logic        fire;

  kcl_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .advance_i (advance),
    .stage_o   (stage)
  );

  kcl_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .stage_i    (stage),
    .advance_i  (advance),
    .fire_o     (fire),
    .result_o   (result)
  );

  kcl_out_stage u_out_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (fire),
    .result_i  (result),
    .advance_o (advance),
    .res_o     (res_o)
  );

endmodule
